@@ src/arpc_pkg.sv @@
// Shared types and constants for the ARP address cache.
// Used by the cell, the top level, the port checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int ENTRIES = 8;

    localparam logic REQ_LEARN   = 1'b0;
    localparam logic REQ_RESOLVE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
    } arpc_req_t;

    typedef struct packed {
        logic        hit;
        logic [47:0] mac_out;
    } arpc_rsp_t;

    // A request walking down the row of cells, one cell per cycle.
    typedef struct packed {
        logic        vld;
        logic        done;
        logic        hit;
        logic        req_type;
        logic [31:0] ip;
        logic [47:0] mac;
    } arpc_tok_t;

    // Unconditional write of an entry, used to overwrite slot 0 when full.
    typedef struct packed {
        logic        en;
        logic [31:0] ip;
        logic [47:0] mac;
    } arpc_fill_t;

endpackage

@@ src/arpc_cell.sv @@
// One cache entry of the ARP address cache, with the register stage that
// hands the walking request on to the next entry. Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  arpc_pkg::arpc_tok_t tok_in,
    input  arpc_pkg::arpc_fill_t fill,
    output arpc_pkg::arpc_tok_t tok_out
);
    import arpc_pkg::*;

    logic [31:0] ip_reg,    ip_next;
    logic [47:0] mac_reg,   mac_next;
    logic        valid_reg, valid_next;
    arpc_tok_t   tok_reg,   tok_next;
    logic        match;

    assign match = valid_reg && (ip_reg == tok_in.ip);

    always_comb begin
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        valid_next = valid_reg;
        tok_next   = tok_in;
        if (fill.en) begin
            ip_next    = fill.ip;
            mac_next   = fill.mac;
            valid_next = 1'b1;
        end else if (tok_in.vld && !tok_in.done) begin
            // Valid entries always form a prefix of the row, so the first
            // empty cell a learn reaches means the key is not held anywhere.
            if (match) begin
                tok_next.done = 1'b1;
                if (tok_in.req_type == REQ_RESOLVE) begin
                    tok_next.hit = 1'b1;
                    tok_next.mac = mac_reg;
                end else begin
                    mac_next = tok_in.mac;
                end
            end else if (!valid_reg && tok_in.req_type == REQ_LEARN) begin
                ip_next       = tok_in.ip;
                mac_next      = tok_in.mac;
                valid_next    = 1'b1;
                tok_next.done = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            tok_reg.vld <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            tok_reg.vld <= tok_next.vld;
        end
        ip_reg                <= ip_next;
        mac_reg               <= mac_next;
        tok_reg.done          <= tok_next.done;
        tok_reg.hit           <= tok_next.hit;
        tok_reg.req_type      <= tok_next.req_type;
        tok_reg.ip            <= tok_next.ip;
        tok_reg.mac           <= tok_next.mac;
    end

    assign tok_out = tok_reg;

endmodule

@@ src/arp_address_cache_core.sv @@
// Top level of the ARP address cache: a row of entry cells that a request
// walks through, plus the output register and its skid slot.
// Depends on arpc_pkg and arpc_cell.
//
//   channel | ports                      | payload
//   s_      | s_valid, s_ready, s_data   | arpc_req_t (req_type, ip_addr, mac_addr)
//   m_      | m_valid, m_ready, m_data   | arpc_rsp_t (hit, mac_out), resolve only
//
// A request enters cell 0 when accepted and moves one cell per cycle through
// every cell's register until it leaves the row; one request is in the row at
// a time, the next being taken once the last has left and, for a resolve, its
// result has reached the output register. A learn of an absent key into a full
// table writes slot 0 in the cycle the request leaves the row. A resolve result
// that meets a stalled output waits in a skid slot. Reset clears all valid bits.
`timescale 1ns / 1ps

module arp_address_cache_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  arpc_pkg::arpc_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output arpc_pkg::arpc_rsp_t m_data
);
    import arpc_pkg::*;

    arpc_tok_t  tok [ENTRIES+1];
    arpc_fill_t fill0;
    arpc_tok_t  exit_tok;
    arpc_rsp_t  res;
    logic       accept, res_fire, learn_done, m_free;

    logic       busy_reg,   busy_next;
    logic       m_valid_reg, m_valid_next;
    arpc_rsp_t  m_data_reg, m_data_next;
    logic       pend_valid_reg, pend_valid_next;
    arpc_rsp_t  pend_data_reg,  pend_data_next;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        tok[0].vld      = accept;
        tok[0].done     = 1'b0;
        tok[0].hit      = 1'b0;
        tok[0].req_type = s_data.req_type;
        tok[0].ip       = s_data.ip_addr;
        // A resolve carries zero so that a miss reports a zero MAC.
        tok[0].mac      = (s_data.req_type == REQ_RESOLVE) ? 48'd0 : s_data.mac_addr;
    end

    assign exit_tok   = tok[ENTRIES];
    assign res_fire   = exit_tok.vld && (exit_tok.req_type == REQ_RESOLVE);
    assign learn_done = exit_tok.vld && (exit_tok.req_type == REQ_LEARN);
    assign res.hit    = exit_tok.hit;
    assign res.mac_out = exit_tok.mac;

    // A learn that found neither its key nor a free slot overwrites slot 0.
    assign fill0.en  = learn_done && !exit_tok.done;
    assign fill0.ip  = exit_tok.ip;
    assign fill0.mac = exit_tok.mac;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        arpc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok[i]),
            .fill    ((i == 0) ? fill0 : arpc_fill_t'('0)),
            .tok_out (tok[i+1])
        );
    end

    assign m_free = !m_valid_reg || m_ready;

    always_comb begin
        busy_next       = busy_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        if (accept) begin
            busy_next = 1'b1;
        end
        if (learn_done) begin
            busy_next = 1'b0;
        end
        if (m_free) begin
            if (pend_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = pend_data_reg;
                pend_valid_next = 1'b0;
                busy_next       = 1'b0;
            end else if (res_fire) begin
                m_valid_next = 1'b1;
                m_data_next  = res;
                busy_next    = 1'b0;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (res_fire) begin
            pend_valid_next = 1'b1;
            pend_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
        m_data_reg    <= m_data_next;
        pend_data_reg <= pend_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/arpc_checker.sv @@
// Port-level checks for the ARP address cache, bound to the top level.
// Depends on arpc_pkg and arp_address_cache_core.
`timescale 1ns / 1ps

module arpc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input arpc_pkg::arpc_req_t s_data,
    input logic                m_valid,
    input logic                m_ready,
    input arpc_pkg::arpc_rsp_t m_data
);
    import arpc_pkg::*;

    // A waiting request holds its value until it is taken.
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while waiting");

    // A stalled result holds its value.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A miss always reports a zero MAC.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.mac_out == 48'd0)
        else $error("miss with nonzero MAC");

    // Only one request is in the cache at a time.
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // A new result only appears after a request was in flight.
    a_res_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a request in flight");

endmodule

bind arp_address_cache_core arpc_checker u_arpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ test/arp_address_cache_core_test.sv @@
// Self-checking testbench for arp_address_cache_core: learn and resolve requests,
// predicted by a table model in a small scoreboard class. Depends on arpc_pkg and the core.
`timescale 1ns / 1ps

module arp_address_cache_core_test;
    import arpc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int QUIET_ITEMS = 200;
    localparam int KEY_POOL = 12;
    localparam int DRAIN_CYCLES = 4 * (ENTRIES + 2);

    // Table model plus the queue of resolve replies not yet seen on m_.
    class arp_lookup_board;
        logic [31:0] slot_ip[ENTRIES];
        logic [47:0] slot_mac[ENTRIES];
        bit          slot_used[ENTRIES];
        arpc_rsp_t   resolve_replies[$];
        int          errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_ip[i] = '0;
                slot_mac[i] = '0;
            end
            errors = 0;
        endfunction

        // Lowest valid slot holding the key, or -1.
        function int find_slot(logic [31:0] key);
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_used[i] && slot_ip[i] == key) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void note_request(arpc_req_t req);
            int        slot;
            arpc_rsp_t reply;
            slot = find_slot(req.ip_addr);
            if (req.req_type == REQ_LEARN) begin
                if (slot >= 0) begin
                    slot_mac[slot] = req.mac_addr;
                end else begin
                    // A full table gives up slot 0.
                    slot = 0;
                    for (int i = ENTRIES - 1; i >= 0; i--) begin
                        if (!slot_used[i]) begin
                            slot = i;
                        end
                    end
                    slot_ip[slot] = req.ip_addr;
                    slot_mac[slot] = req.mac_addr;
                    slot_used[slot] = 1'b1;
                end
            end else begin
                reply.hit = (slot >= 0);
                reply.mac_out = (slot >= 0) ? slot_mac[slot] : '0;
                resolve_replies.push_back(reply);
            end
        endfunction

        function void check_result(arpc_rsp_t got);
            arpc_rsp_t want;
            if (resolve_replies.size() == 0) begin
                $error("unexpected result: hit %0b, mac_out %012h", got.hit, got.mac_out);
                errors++;
                return;
            end
            want = resolve_replies.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0b, actual %0b", want.hit, got.hit);
                errors++;
            end
            if (got.mac_out !== want.mac_out) begin
                $error("mac_out: expected %012h, actual %012h", want.mac_out, got.mac_out);
                errors++;
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    arpc_req_t s_data;
    logic      m_valid;
    logic      m_ready;
    arpc_rsp_t m_data;

    arp_lookup_board board;
    bit              quiet;
    int              cycle_count;
    int              stall_left;
    logic [31:0]     key_pool[KEY_POOL];

    arp_address_cache_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("arp_address_cache_core regression: fail");
        $finish;
    end

    // Both handshakes are observed here, so prediction follows acceptance order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.note_request(s_data);
            end
            if (m_valid && m_ready) begin
                board.check_result(m_data);
            end
        end
    end

    // Result side: random stall bursts, none once the run goes quiet.
    initial begin
        m_ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [47:0] random_mac();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return bits[47:0];
        endcase
    endfunction

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom;
        end
        return key_pool[$urandom_range(0, KEY_POOL - 1)];
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken, or after a random idle gap behind it.
    task automatic send_request(input logic kind, input logic [31:0] ip, input logic [47:0] mac);
        arpc_req_t req;
        int        gap;
        req.req_type = kind;
        req.ip_addr = ip;
        req.mac_addr = mac;
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        board = new();
        quiet = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < KEY_POOL; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, extreme keys and MACs, update in place,
        // filling every slot, and eviction of slot 0 once the table is full.
        send_request(REQ_RESOLVE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_request(REQ_LEARN, 32'h0000_0000, 48'h0000_0000_0000);
        send_request(REQ_RESOLVE, 32'h0000_0000, 48'h0000_0000_0000);
        send_request(REQ_LEARN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(REQ_RESOLVE, 32'hFFFF_FFFF, 48'h0000_0000_0000);
        send_request(REQ_LEARN, 32'h0000_0000, 48'h1234_5678_9ABC);
        send_request(REQ_RESOLVE, 32'h0000_0000, 48'h5555_5555_5555);
        for (int i = 2; i < ENTRIES; i++) begin
            send_request(REQ_LEARN, 32'hC0A8_0100 + i, 48'h0200_0000_0000 + i);
        end
        send_request(REQ_LEARN, 32'h0A00_0001, 48'hAAAA_AAAA_AAAA);
        send_request(REQ_RESOLVE, 32'h0000_0000, 48'h0);
        send_request(REQ_RESOLVE, 32'h0A00_0001, 48'h0);
        send_request(REQ_RESOLVE, 32'hFFFF_FFFF, 48'h0);
        send_request(REQ_LEARN, 32'h0A00_0001, 48'h5555_5555_5555);
        send_request(REQ_RESOLVE, 32'h0A00_0001, 48'h0);
        send_request(REQ_RESOLVE, 32'hC0A8_0100 + ENTRIES - 1, 48'h0);
        send_request(REQ_RESOLVE, 32'h7F00_0001, 48'h0);

        // Random: keys mostly from a pool a bit larger than the table, so hits,
        // updates, misses and evictions all keep happening.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            send_request($urandom_range(0, 1) ? REQ_RESOLVE : REQ_LEARN, pick_key(), random_mac());
        end
        s_valid <= 1'b0;

        while (board.resolve_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0 && board.resolve_replies.size() == 0) begin
            $display("arp_address_cache_core regression: pass");
        end else begin
            $display("arp_address_cache_core regression: fail");
        end
        $finish;
    end

endmodule

@@ arp_address_cache_core.f @@
src/arpc_pkg.sv
src/arpc_cell.sv
src/arp_address_cache_core.sv
src/arpc_checker.sv
test/arp_address_cache_core_test.sv
